// ===== rtl/core/msfw_pkg.sv =====
// ----------------------------------------------------------------------------
// msfw_pkg
// Shared constants, payload types and the request passed along the cell row
// of the maximum-sum fixed-window block.
// ----------------------------------------------------------------------------
package msfw_pkg;

    localparam int MAX_WINDOW  = 1024;
    localparam int MAX_ITEMS   = 65536;
    localparam int NUM_CELLS   = 4;
    localparam int BANK_DEPTH  = MAX_WINDOW / NUM_CELLS;

    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int BANK_W      = $clog2(NUM_CELLS);
    localparam int OFF_W       = $clog2(BANK_DEPTH);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 2);

    localparam int VAL_W       = 32;
    localparam int K_W         = 11;
    localparam int SUM_W       = 43;
    localparam int MAXSUM_W    = 42;
    localparam int IDX_W       = 16;
    localparam int STATUS_W    = 2;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register map (word index taken from paddr[2])
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [K_W-1:0] WINDOW_LEN_RST = K_W'(1);

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IMPOSSIBLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [MAXSUM_W-1:0] max_sum;
        logic [IDX_W-1:0]           left_index;
        logic [IDX_W-1:0]           right_index;
        logic [STATUS_W-1:0]        status;
    } out_item_t;

    // one item on its way down the cell row
    typedef struct packed {
        logic                    valid;
        logic                    wr_en;
        logic                    rd_en;
        logic [SLOT_W-1:0]       wr_slot;
        logic [SLOT_W-1:0]       rd_slot;
        logic [VAL_W-1:0]        value;
        logic [VAL_W-1:0]        old_value;
        logic                    last;
        logic                    use_sum;
        logic                    first_win;
        logic                    later_win;
        logic [IDX_W-1:0]        start;
        logic [K_W-1:0]          k;
        logic [STATUS_W-1:0]     status;
    } cell_req_t;

endpackage

// ===== rtl/core/msfw_front.sv =====
// ----------------------------------------------------------------------------
// msfw_front
// Item counter and per-item decode: works out ring slots, window flags and
// the final status, and launches the item into the cell row.
// ----------------------------------------------------------------------------
module msfw_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  msfw_pkg::in_item_t          item_i,
    input  logic [msfw_pkg::K_W-1:0]    window_len,
    output msfw_pkg::cell_req_t         req_o
);

    logic [msfw_pkg::CNT_W-1:0] count_reg;
    logic [msfw_pkg::CNT_W-1:0] count_next;
    logic [msfw_pkg::CNT_W-1:0] count_after;
    logic [msfw_pkg::CNT_W-1:0] k_ext;
    logic [msfw_pkg::CNT_W-1:0] start_full;
    logic                       k_ok;
    logic                       in_range;
    logic                       use_sum;

    always_comb begin
        k_ext    = msfw_pkg::CNT_W'(window_len);
        k_ok     = (window_len != '0) &&
                   (window_len <= msfw_pkg::K_W'(msfw_pkg::MAX_WINDOW));
        in_range = count_reg < msfw_pkg::CNT_W'(msfw_pkg::MAX_ITEMS);
        use_sum  = in_range && k_ok;

        // count saturates one past the limit
        if (count_reg <= msfw_pkg::CNT_W'(msfw_pkg::MAX_ITEMS)) begin
            count_after = count_reg + msfw_pkg::CNT_W'(1);
        end else begin
            count_after = count_reg;
        end

        start_full = count_reg - k_ext + msfw_pkg::CNT_W'(1);

        req_o.valid     = accept;
        req_o.wr_en     = in_range;
        req_o.rd_en     = use_sum && (count_reg >= k_ext);
        req_o.wr_slot   = count_reg[msfw_pkg::SLOT_W-1:0];
        req_o.rd_slot   = count_reg[msfw_pkg::SLOT_W-1:0] -
                          window_len[msfw_pkg::SLOT_W-1:0];
        req_o.value     = item_i.value;
        req_o.old_value = '0;
        req_o.last      = item_i.last;
        req_o.use_sum   = use_sum;
        req_o.first_win = use_sum && (count_after == k_ext);
        req_o.later_win = use_sum && (count_reg >= k_ext);
        req_o.start     = start_full[msfw_pkg::IDX_W-1:0];
        req_o.k         = window_len;

        if (count_after > msfw_pkg::CNT_W'(msfw_pkg::MAX_ITEMS)) begin
            req_o.status = msfw_pkg::STATUS_TOO_LONG;
        end else if (!k_ok || (k_ext > count_after)) begin
            req_o.status = msfw_pkg::STATUS_IMPOSSIBLE;
        end else begin
            req_o.status = msfw_pkg::STATUS_OK;
        end

        count_next = count_reg;
        if (accept) begin
            count_next = item_i.last ? '0 : count_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/msfw_cell.sv =====
// ----------------------------------------------------------------------------
// msfw_cell
// One cell of the row: owns one bank of the ring of recent values, writes
// and reads it when the item's slot falls in its bank, and hands the item
// on to the next cell every cycle that adv is high.
// ----------------------------------------------------------------------------
module msfw_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [msfw_pkg::BANK_W-1:0]   cell_id,
    input  msfw_pkg::cell_req_t           req_i,
    output msfw_pkg::cell_req_t           req_o
);

    logic [msfw_pkg::VAL_W-1:0] bank_mem [msfw_pkg::BANK_DEPTH];
    logic [msfw_pkg::VAL_W-1:0] rd_q;
    msfw_pkg::cell_req_t        req_reg;
    logic                       valid_reg;
    logic                       rd_hit_reg;
    logic                       rd_hit;
    logic                       wr_hit;

    assign rd_hit = req_i.valid && req_i.rd_en &&
        (req_i.rd_slot[msfw_pkg::SLOT_W-1:msfw_pkg::OFF_W] == cell_id);
    assign wr_hit = req_i.valid && req_i.wr_en &&
        (req_i.wr_slot[msfw_pkg::SLOT_W-1:msfw_pkg::OFF_W] == cell_id);

    // read sees the old entry when a full-length window hits its own slot
    always_ff @(posedge aclk) begin
        if (adv) begin
            req_reg <= req_i;
            if (rd_hit) begin
                rd_q <= bank_mem[req_i.rd_slot[msfw_pkg::OFF_W-1:0]];
            end
            if (wr_hit) begin
                bank_mem[req_i.wr_slot[msfw_pkg::OFF_W-1:0]] <= req_i.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            rd_hit_reg <= 1'b0;
        end else if (adv) begin
            valid_reg  <= req_i.valid;
            rd_hit_reg <= rd_hit;
        end
    end

    always_comb begin
        req_o       = req_reg;
        req_o.valid = valid_reg;
        if (rd_hit_reg) begin
            req_o.old_value = rd_q;
        end
    end

endmodule

// ===== rtl/core/msfw_acc.sv =====
// ----------------------------------------------------------------------------
// msfw_acc
// Running window sum, best-window tracking and the result register.
// ----------------------------------------------------------------------------
module msfw_acc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  msfw_pkg::cell_req_t   req_i,
    input  logic                  m_ready,
    output logic                  adv,
    output logic                  m_valid,
    output msfw_pkg::out_item_t   m_data
);

    localparam int EXT_W = msfw_pkg::SUM_W - msfw_pkg::VAL_W;

    logic signed [msfw_pkg::SUM_W-1:0] run_sum_reg;
    logic signed [msfw_pkg::SUM_W-1:0] best_sum_reg;
    logic [msfw_pkg::IDX_W-1:0]        best_start_reg;
    logic signed [msfw_pkg::SUM_W-1:0] run_sum_next;
    logic signed [msfw_pkg::SUM_W-1:0] best_sum_next;
    logic [msfw_pkg::IDX_W-1:0]        best_start_next;
    logic signed [msfw_pkg::SUM_W-1:0] new_ext;
    logic signed [msfw_pkg::SUM_W-1:0] old_ext;
    logic signed [msfw_pkg::SUM_W-1:0] sum_new;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    msfw_pkg::out_item_t               m_data_reg;
    msfw_pkg::out_item_t               result;
    logic                              step;

    assign adv  = !m_valid_reg || m_ready;
    assign step = adv && req_i.valid;

    always_comb begin
        new_ext = {{EXT_W{req_i.value[msfw_pkg::VAL_W-1]}}, req_i.value};
        if (req_i.rd_en) begin
            old_ext = {{EXT_W{req_i.old_value[msfw_pkg::VAL_W-1]}}, req_i.old_value};
        end else begin
            old_ext = '0;
        end
        sum_new = run_sum_reg + new_ext - old_ext;

        run_sum_next    = run_sum_reg;
        best_sum_next   = best_sum_reg;
        best_start_next = best_start_reg;
        if (req_i.use_sum) begin
            run_sum_next = sum_new;
            // strict compare keeps the earliest window on ties
            if (req_i.first_win) begin
                best_sum_next   = sum_new;
                best_start_next = '0;
            end else if (req_i.later_win && (sum_new > best_sum_reg)) begin
                best_sum_next   = sum_new;
                best_start_next = req_i.start;
            end
        end

        result.status = req_i.status;
        if (req_i.status == msfw_pkg::STATUS_OK) begin
            result.max_sum     = best_sum_next[msfw_pkg::MAXSUM_W-1:0];
            result.left_index  = best_start_next;
            result.right_index = best_start_next + msfw_pkg::IDX_W'(req_i.k) -
                                 msfw_pkg::IDX_W'(1);
        end else begin
            result.max_sum     = '0;
            result.left_index  = '0;
            result.right_index = '0;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (step && req_i.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg    <= '0;
            best_sum_reg   <= '0;
            best_start_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                if (req_i.last) begin
                    run_sum_reg    <= '0;
                    best_sum_reg   <= '0;
                    best_start_reg <= '0;
                end else begin
                    run_sum_reg    <= run_sum_next;
                    best_sum_reg   <= best_sum_next;
                    best_start_reg <= best_start_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && req_i.last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/max_sum_fixed_window_top.sv =====
// ----------------------------------------------------------------------------
// max_sum_fixed_window_top
// Streaming search for the fixed-length window with the largest sum.
// Throughput: one item per cycle; s_ready drops only while a result waits.
// The item marked last passes through the four registered cells of the ring row
// and then the result register of the sum stage before m_valid rises.
// A stall on the result side holds the whole row in place.
// Reset (synchronous, aresetn low): window_len to 1, stream state cleared;
// the ring holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module max_sum_fixed_window_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  msfw_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output msfw_pkg::out_item_t                  m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [msfw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [msfw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [msfw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [msfw_pkg::K_W-1:0] window_len_reg;
    logic [msfw_pkg::K_W-1:0] window_len_next;
    logic                     adv;
    logic                     accept;
    logic                     reg_sel;

    msfw_pkg::cell_req_t chain [msfw_pkg::NUM_CELLS+1];

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == msfw_pkg::REG_WINDOW_LEN);

    always_comb begin
        window_len_next = window_len_reg;
        if (psel && penable && pwrite && reg_sel) begin
            window_len_next = pwdata[msfw_pkg::K_W-1:0];
        end
        prdata = '0;
        if (reg_sel) begin
            prdata = msfw_pkg::APB_DATA_W'(window_len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= msfw_pkg::WINDOW_LEN_RST;
        end else begin
            window_len_reg <= window_len_next;
        end
    end

    assign s_ready = adv;
    assign accept  = s_valid && adv;

    msfw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .item_i     (s_data),
        .window_len (window_len_reg),
        .req_o      (chain[0])
    );

    for (genvar g = 0; g < msfw_pkg::NUM_CELLS; g++) begin : g_cell
        msfw_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .cell_id (msfw_pkg::BANK_W'(g)),
            .req_i   (chain[g]),
            .req_o   (chain[g+1])
        );
    end

    msfw_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (chain[msfw_pkg::NUM_CELLS]),
        .m_ready (m_ready),
        .adv     (adv),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// ===== dv/msfw_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msfw_window_checker
// Watches the item, result and register ports of the maximum-sum window
// block, keeps its own copy of the window search, and compares each result
// taken from the block with the oldest one it has worked out.
// ----------------------------------------------------------------------------
module msfw_window_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  msfw_pkg::in_item_t                 s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  msfw_pkg::out_item_t                m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [msfw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msfw_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                 fail_count,
    output int                                 pending_results
);
    import msfw_pkg::*;

    logic [K_W-1:0]          win_len;
    logic signed [VAL_W-1:0] ring [MAX_WINDOW];
    int unsigned             ring_wr;
    int unsigned             stream_count;
    longint                  run_sum;
    longint                  best_sum;
    int unsigned             best_start;
    out_item_t               best_window_q[$];

    task automatic clear_stream();
        ring_wr      = 0;
        stream_count = 0;
        run_sum      = 0;
        best_sum     = 0;
        best_start   = 0;
    endtask

    // one item into the running window; queues the result on the last item
    task automatic track_item(input in_item_t it);
        int unsigned k;
        bit          k_fine;
        longint      leaving;
        out_item_t   res;
        k      = win_len;
        k_fine = (k >= 1) && (k <= MAX_WINDOW);
        if (stream_count < MAX_ITEMS) begin
            if (k_fine) begin
                leaving = 0;
                if (stream_count >= k)
                    leaving = longint'(ring[(ring_wr + MAX_WINDOW - k) % MAX_WINDOW]);
                run_sum += longint'(it.value) - leaving;
                if (stream_count + 1 == k) begin
                    best_sum   = run_sum;
                    best_start = 0;
                end else if (stream_count >= k && run_sum > best_sum) begin
                    // strict compare keeps the earliest window on a tie
                    best_sum   = run_sum;
                    best_start = stream_count - k + 1;
                end
            end
            ring[ring_wr] = it.value;
            ring_wr       = (ring_wr + 1) % MAX_WINDOW;
        end
        // count saturates one past the limit
        if (stream_count <= MAX_ITEMS)
            stream_count++;
        if (it.last) begin
            res = '0;
            if (stream_count > MAX_ITEMS) begin
                res.status = STATUS_TOO_LONG;
            end else if (!k_fine || k > stream_count) begin
                res.status = STATUS_IMPOSSIBLE;
            end else begin
                res.status      = STATUS_OK;
                res.max_sum     = MAXSUM_W'(best_sum);
                res.left_index  = IDX_W'(best_start);
                res.right_index = IDX_W'(best_start + k - 1);
            end
            best_window_q.push_back(res);
            clear_stream();
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (best_window_q.size() == 0) begin
            $error("unexpected result: max_sum %0d left %0d right %0d status %0d",
                   got.max_sum, got.left_index, got.right_index, got.status);
            fail_count++;
        end else begin
            want = best_window_q.pop_front();
            if (got.max_sum !== want.max_sum) begin
                $error("max_sum: expected %0d, got %0d", want.max_sum, got.max_sum);
                fail_count++;
            end
            if (got.left_index !== want.left_index) begin
                $error("left_index: expected %0d, got %0d",
                       want.left_index, got.left_index);
                fail_count++;
            end
            if (got.right_index !== want.right_index) begin
                $error("right_index: expected %0d, got %0d",
                       want.right_index, got.right_index);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_len = WINDOW_LEN_RST;
            clear_stream();
            best_window_q.delete();
        end else begin
            // an item taken at this edge still sees the old window length
            if (s_valid && s_ready)
                track_item(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
            if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_LEN)
                win_len = pwdata[K_W-1:0];
        end
        pending_results = best_window_q.size();
    end

endmodule

// ===== dv/max_sum_fixed_window_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_sum_fixed_window_top_tb
// Drives arrays of signed values through the maximum-sum window block under
// a range of window lengths, with random gaps on both channels, and leaves
// the checking to msfw_window_checker. Covers zero and oversized windows,
// streams shorter than the window, extreme sums, ties and ring wrap.
// ----------------------------------------------------------------------------
module max_sum_fixed_window_top_tb;
    import msfw_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 220;
    localparam int SETTLE       = 8;
    localparam logic [APB_ADDR_W-1:0] WINDOW_LEN_ADDR = {REG_WINDOW_LEN, 2'b00};

    typedef enum {
        FILL_RANDOM, FILL_NARROW, FILL_MAX, FILL_MIN, FILL_SWING, FILL_TIES, FILL_RISING
    } fill_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int items_sent  = 0;
    int sink_wait   = 0;
    bit src_calm    = 1'b0;
    bit sink_calm   = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    max_sum_fixed_window_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    msfw_window_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // result side: after each item taken, hold ready low for a drawn stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else if (m_ready) begin
            if (m_valid) begin
                sink_wait = sink_calm ? 0 : $urandom_range(17, 0);
                if (sink_wait != 0)
                    m_ready <= 1'b0;
            end
        end else begin
            if (sink_wait > 0)
                sink_wait--;
            if (sink_wait == 0)
                m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("max_sum_fixed_window_top_tb: errors");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] fill_value(input fill_t fill, input int n);
        case (fill)
            FILL_MAX:    return {1'b0, {(VAL_W-1){1'b1}}};
            FILL_MIN:    return {1'b1, {(VAL_W-1){1'b0}}};
            FILL_SWING:  return (n % 2 == 0) ? {1'b0, {(VAL_W-1){1'b1}}}
                                             : {1'b1, {(VAL_W-1){1'b0}}};
            FILL_TIES:   return (n % 3 == 0) ? 5 : 1;
            FILL_RISING: return n;
            FILL_NARROW: return $urandom_range(6, 0) - 3;
            default:     return $urandom;
        endcase
    endfunction

    // called at a clock edge; valid stays up across back-to-back items
    task automatic push_item(input logic signed [VAL_W-1:0] v, input logic is_last);
        int gap;
        gap = src_calm ? 0 : $urandom_range(17, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{value: v, last: is_last};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_stream(input int len, input fill_t fill);
        for (int n = 0; n < len; n++)
            push_item(fill_value(fill, n), n == len - 1);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_window_len(input logic [K_W-1:0] k);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_LEN_ADDR;
        pwdata  <= {21'($urandom), k};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int              first_random;
        int              len;
        int              k_int;
        int              n_streams;
        logic [K_W-1:0]  k_pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window length from reset, including a one-item array
        send_stream(1, FILL_RANDOM);
        send_stream(4, FILL_RANDOM);
        wait_idle();

        write_window_len(K_W'(0));
        send_stream(3, FILL_RANDOM);
        wait_idle();

        // shorter than window, exact fit, then ties
        write_window_len(K_W'(3));
        send_stream(2, FILL_RANDOM);
        send_stream(3, FILL_RANDOM);
        send_stream(9, FILL_TIES);
        wait_idle();

        // full-scale swings must not wrap at 32 bits
        write_window_len(K_W'(2));
        send_stream(7, FILL_SWING);
        send_stream(5, FILL_MIN);
        send_stream(8, FILL_TIES);
        wait_idle();

        src_calm = 1'b1;
        write_window_len(K_W'(MAX_WINDOW + 1));
        send_stream(6, FILL_RANDOM);
        wait_idle();
        write_window_len({K_W{1'b1}});
        send_stream(3, FILL_RANDOM);
        wait_idle();

        // widest window: largest sum, then ring wrap onto the slot being written
        write_window_len(K_W'(MAX_WINDOW));
        send_stream(MAX_WINDOW + 2, FILL_MAX);
        wait_idle();

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            src_calm  = ($urandom_range(4, 0) == 0);
            sink_calm = ($urandom_range(4, 0) == 0);
            case ($urandom_range(31, 0))
                0, 1, 2: k_pick = '0;
                3, 4, 5: k_pick = K_W'($urandom_range(2047, MAX_WINDOW + 1));
                6:       k_pick = K_W'($urandom_range(64, 17));
                default: k_pick = K_W'($urandom_range(16, 1));
            endcase
            k_int = k_pick;
            write_window_len(k_pick);
            n_streams = (k_int > 16) ? 1 : $urandom_range(4, 1);
            repeat (n_streams) begin
                if (k_int >= 1 && k_int <= MAX_WINDOW)
                    len = ($urandom_range(5, 0) == 0) ? $urandom_range(k_int, 1)
                                                      : k_int + $urandom_range(24, 0);
                else
                    len = $urandom_range(12, 1);
                send_stream(len, ($urandom_range(3, 0) == 0) ? FILL_NARROW : FILL_RANDOM);
            end
            wait_idle();
        end

        wait_idle();
        if (fail_count == 0 && pending_results == 0)
            $display("max_sum_fixed_window_top_tb: clean");
        else
            $display("max_sum_fixed_window_top_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/msfw_pkg.sv
rtl/core/msfw_front.sv
rtl/core/msfw_cell.sv
rtl/core/msfw_acc.sv
rtl/core/max_sum_fixed_window_top.sv
dv/msfw_window_checker.sv
dv/max_sum_fixed_window_top_tb.sv
